// File: src/rat_pkg.sv
package rat_pkg;

    localparam logic [1:0] OP_SCAN   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_ACK    = 2'd2;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam int MAX_RESULTS = 8;
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [31:0] start_time;
        logic [31:0] repeat_interval;
        logic [15:0] retry_window;
        logic [7:0]  destination;
        logic [7:0]  device_id;
        logic [7:0]  command_code;
        logic [7:0]  command_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_destination;
        logic [7:0] out_device;
        logic [7:0] out_command;
        logic [7:0] out_value;
        logic       status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] interval;
        logic [15:0] window;
        logic [7:0]  dest;
        logic [7:0]  device;
        logic [7:0]  code;
        logic [7:0]  value;
    } entry_t;

endpackage

// File: src/repeating_alarm_table.sv
// create searches for a free slot; acknowledge reads and compares each alarm visited, then reports status
// scan reads and compares each alarm visited, sends or advances due ones, then flushes the held command
// one item at a time; the single adder and the entry memory (one write, one read port) set the pace
// a result goes into an output register, so the next item may start while it waits
// reset clears the valid bits, the alarm count and all handshake state; the table is empty
module repeating_alarm_table #(
    parameter int ENTRIES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  rat_pkg::in_item_t    req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rat_pkg::out_item_t   rsp
);
    import rat_pkg::*;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_ADV      = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_FLUSH    = 4'd6;
    localparam logic [3:0] S_ACK_RD   = 4'd7;
    localparam logic [3:0] S_ACK_CMP  = 4'd8;
    localparam logic [3:0] S_STATUS   = 4'd9;

    logic [3:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [CNT_W-1:0]  rank_reg, rank_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              status_reg, status_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0] order_reg [ENTRIES];
    logic [SLOT_W-1:0] order_next [ENTRIES];
    logic              pend_valid_reg, pend_valid_next;
    out_item_t         pend_reg, pend_next;
    logic              rsp_valid_reg, rsp_valid_next;
    out_item_t         rsp_reg, rsp_next;

    entry_t            mem [ENTRIES];
    entry_t            rd_data_reg;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata;

    logic [31:0]       add_a, add_b;
    logic              add_cin;
    logic [32:0]       add_sum;
    logic              past_due, in_window, out_free;
    logic [SLOT_W-1:0] rank_idx;
    out_item_t         cmd_item;

    assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign past_due  = add_sum[32] && (add_sum[31:0] != 32'd0);
    assign in_window = add_sum[31:0] < {16'd0, rd_data_reg.window};
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rank_idx  = rank_reg[SLOT_W-1:0];

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        cmd_item                 = '0;
        cmd_item.kind            = KIND_CMD;
        cmd_item.out_destination = rd_data_reg.dest;
        cmd_item.out_device      = rd_data_reg.device;
        cmd_item.out_command     = rd_data_reg.code;
        cmd_item.out_value       = rd_data_reg.value;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        rank_next       = rank_reg;
        used_next       = used_reg;
        n_next          = n_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        valid_next      = valid_reg;
        order_next      = order_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = order_reg[rank_idx];
        // shared adder defaults to now - due
        add_a           = item_reg.now;
        add_b           = ~rd_data_reg.due;
        add_cin         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    rank_next = '0;
                    n_next    = '0;
                    case (req.op)
                        OP_SCAN:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        OP_CREATE:
                        begin
                            if (used_reg == CNT_W'(ENTRIES))
                            begin
                                status_next = ST_FAIL;
                                state_next  = S_STATUS;
                            end
                            else
                            begin
                                slot_next  = '0;
                                state_next = S_FIND;
                            end
                        end
                        OP_ACK:
                        begin
                            state_next = S_ACK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                if (!valid_reg[slot_reg])
                begin
                    mem_we             = 1'b1;
                    mem_wdata.due      = item_reg.start_time;
                    mem_wdata.interval = item_reg.repeat_interval;
                    mem_wdata.window   = item_reg.retry_window;
                    mem_wdata.dest     = item_reg.destination;
                    mem_wdata.device   = item_reg.device_id;
                    mem_wdata.code     = item_reg.command_code;
                    mem_wdata.value    = item_reg.command_value;
                    valid_next[slot_reg] = 1'b1;
                    order_next[used_reg[SLOT_W-1:0]] = slot_reg;
                    used_next   = used_reg + CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_STATUS;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            S_SCAN_RD:
            begin
                if (rank_reg >= used_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    slot_next  = order_reg[rank_idx];
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (!valid_reg[slot_reg] || !past_due)
                begin
                    rank_next  = rank_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
                else if (in_window)
                begin
                    if (n_reg < N_W'(MAX_RESULTS))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rank_next  = rank_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else if (rd_data_reg.interval != 32'd0)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    // one-shot alarm expired: drop it, next alarm moves into this rank
                    valid_next[slot_reg] = 1'b0;
                    for (int i = 0; i < ENTRIES - 1; i++)
                    begin
                        if (CNT_W'(i) >= rank_reg)
                        begin
                            order_next[i] = order_reg[i + 1];
                        end
                    end
                    used_next  = used_reg - CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_ADV:
            begin
                add_a         = rd_data_reg.due;
                add_b         = rd_data_reg.interval;
                add_cin       = 1'b0;
                mem_we        = 1'b1;
                mem_wdata.due = add_sum[31:0];
                if (item_reg.op == OP_ACK)
                begin
                    status_next = ST_OK;
                    state_next  = S_STATUS;
                end
                else
                begin
                    rank_next  = rank_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_EMIT:
            begin
                // the held command goes out here once a later one shows it is not last; else S_FLUSH sends it as last
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = pend_reg;
                    end
                    pend_next       = cmd_item;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + N_W'(1);
                    rank_next       = rank_reg + CNT_W'(1);
                    state_next      = S_SCAN_RD;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = pend_reg;
                    rsp_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_ACK_RD:
            begin
                if (rank_reg >= used_reg)
                begin
                    status_next = ST_FAIL;
                    state_next  = S_STATUS;
                end
                else
                begin
                    mem_re     = 1'b1;
                    slot_next  = order_reg[rank_idx];
                    state_next = S_ACK_CMP;
                end
            end

            S_ACK_CMP:
            begin
                if (valid_reg[slot_reg] && rd_data_reg.dest == item_reg.destination)
                begin
                    if (past_due && rd_data_reg.value == item_reg.command_value)
                    begin
                        if (rd_data_reg.interval != 32'd0)
                        begin
                            state_next = S_ADV;
                        end
                        else
                        begin
                            valid_next[slot_reg] = 1'b0;
                            for (int i = 0; i < ENTRIES - 1; i++)
                            begin
                                if (CNT_W'(i) >= rank_reg)
                                begin
                                    order_next[i] = order_reg[i + 1];
                                end
                            end
                            used_next   = used_reg - CNT_W'(1);
                            status_next = ST_OK;
                            state_next  = S_STATUS;
                        end
                    end
                    else
                    begin
                        status_next = ST_FAIL;
                        state_next  = S_STATUS;
                    end
                end
                else
                begin
                    rank_next  = rank_reg + CNT_W'(1);
                    state_next = S_ACK_RD;
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '0;
                    rsp_next.kind   = (item_reg.op == OP_CREATE) ? KIND_CREATE : KIND_ACK;
                    rsp_next.status = status_reg;
                    rsp_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rank_reg       <= '0;
            used_reg       <= '0;
            n_reg          <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rank_reg       <= rank_next;
            used_reg       <= used_next;
            n_reg          <= n_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        order_reg  <= order_next;
        pend_reg   <= pend_next;
        rsp_reg    <= rsp_next;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(ENTRIES))
        else $error("alarm count above table size");

    a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(used_reg))
        else $error("alarm count out of step with valid bits");

    a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held command left over after scan");

    a_send_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_RESULTS))
        else $error("too many commands sent in one scan");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.kind != KIND_CMD) |-> rsp_reg.last)
        else $error("status item not marked last");

endmodule
